FILE: sv/sts_pkg.sv
// Shared types, constants and fixed-point helpers for the stereo tube saturator.
// No dependencies; every other source file uses this package.
package sts_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int FRAC = 28;
   localparam int WW = 72;
   localparam int MUL_STEPS = 32;
   localparam int DIV_STEPS = 40;

   typedef logic signed [WW-1:0] wide_type;
   typedef logic signed [31:0] state_type;

   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 18;

   localparam logic [CSR_IDX_BITS-1:0] CSR_INPUT_GAIN = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DRIVE = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BIAS = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EVEN_WEIGHT = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ODD_WEIGHT = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WET_MIX = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUTPUT_GAIN = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HF_COEFF = 3'd7;

   localparam logic [17:0] RST_INPUT_GAIN = 18'd65536;
   localparam logic [16:0] RST_DRIVE = 17'd19661;
   localparam logic signed [17:0] RST_BIAS = 18'sd13107;
   localparam logic [16:0] RST_EVEN_WEIGHT = 17'd39322;
   localparam logic [16:0] RST_ODD_WEIGHT = 17'd26214;
   localparam logic [16:0] RST_WET_MIX = 17'd32768;
   localparam logic [16:0] RST_OUTPUT_GAIN = 17'd65536;
   localparam logic [15:0] RST_HF_COEFF = 16'd38628;

   localparam wide_type UNITY_Q16 = 72'sd65536;
   localparam wide_type TANH_K27 = 72'sd7247757312;
   localparam wide_type TANH_LIM = 72'sd805306368;
   localparam wide_type DC_COEFF = 72'sd1068373115;
   localparam logic [16:0] LP_DRIVE_MIN = 17'd6553;

   localparam logic [3:0] STEP_U = 4'd0;
   localparam logic [3:0] STEP_DRV = 4'd1;
   localparam logic [3:0] STEP_TSQ = 4'd2;
   localparam logic [3:0] STEP_TNUM = 4'd3;
   localparam logic [3:0] STEP_TDIV = 4'd4;
   localparam logic [3:0] STEP_ODD = 4'd5;
   localparam logic [3:0] STEP_EMUL = 4'd6;
   localparam logic [3:0] STEP_OMUL = 4'd7;
   localparam logic [3:0] STEP_BLEND = 4'd8;
   localparam logic [3:0] STEP_DC = 4'd9;
   localparam logic [3:0] STEP_LP = 4'd10;
   localparam logic [3:0] STEP_MIXD = 4'd11;
   localparam logic [3:0] STEP_MIXW = 4'd12;
   localparam logic [3:0] STEP_OG = 4'd13;

   localparam logic [1:0] TSEL_BIASED = 2'd0;
   localparam logic [1:0] TSEL_BIAS = 2'd1;
   localparam logic [1:0] TSEL_ODD = 2'd2;

   typedef struct packed {
      logic load;
      logic start;
      logic finish;
      logic push;
      logic [3:0] step;
      logic [1:0] tsel;
      logic ch;
   } cmd_type;

   typedef struct packed {
      logic unit_done;
      logic out_free;
   } status_type;

   function automatic wide_type rnd_shift(wide_type v, int k);
      wide_type r;
      if (k == 0) begin
         r = v;
      end else begin
         r = (v + (wide_type'(1) <<< (k - 1))) >>> k;
      end
      return r;
   endfunction

   function automatic wide_type clampw(wide_type v, wide_type lo, wide_type hi);
      wide_type r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic state_type sat32(wide_type v);
      state_type r;
      if (v > 72'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -72'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = $signed(v[31:0]);
      end
      return r;
   endfunction

   function automatic logic [WW-1:0] absw(wide_type v);
      logic [WW-1:0] r;
      if (v < 0) begin
         r = $unsigned(-v);
      end else begin
         r = $unsigned(v);
      end
      return r;
   endfunction

endpackage

FILE: sv/sts_req_if.sv
// Input channel interface: valid/ready handshake with a stereo sample word.
// Depends on sts_pkg for the default sample width.
interface sts_req_if #(parameter int SAMPLE_BITS = sts_pkg::SAMPLE_BITS_DEF);
   logic valid;
   logic ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;
   modport source(output valid, left_in, right_in, input ready);
   modport sink(input valid, left_in, right_in, output ready);
endinterface

FILE: sv/sts_rsp_if.sv
// Result channel interface: valid/ready handshake with a processed stereo word.
// Depends on sts_pkg for the default sample width.
interface sts_rsp_if #(parameter int SAMPLE_BITS = sts_pkg::SAMPLE_BITS_DEF);
   logic valid;
   logic ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   modport source(output valid, left_out, right_out, input ready);
   modport sink(input valid, left_out, right_out, output ready);
endinterface

FILE: sv/sts_mul.sv
// Shift-add signed multiplier, one multiplier bit per cycle over the low MUL_STEPS bits of |b|.
// Depends on sts_pkg.
module sts_mul (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  sts_pkg::wide_type a,
   input  sts_pkg::wide_type b,
   output logic done,
   output sts_pkg::wide_type p
);
   import sts_pkg::*;

   localparam int CNT_BITS = $clog2(MUL_STEPS);

   logic busy_ff;
   logic done_ff;
   logic neg_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [WW-1:0] am_ff;
   logic [WW-1:0] acc_ff;
   logic [MUL_STEPS-1:0] bm_ff;
   logic [WW-1:0] b_mag;

   assign b_mag = absw(b);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
            am_ff <= absw(a);
            bm_ff <= b_mag[MUL_STEPS-1:0];
            acc_ff <= '0;
            neg_ff <= (a < 0) ^ (b < 0);
         end else if (busy_ff) begin
            acc_ff <= acc_ff + (bm_ff[0] ? am_ff : '0);
            am_ff <= am_ff << 1;
            bm_ff <= bm_ff >> 1;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(MUL_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign p = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);

endmodule

FILE: sv/sts_div.sv
// Restoring signed divider truncating toward zero, one quotient bit per cycle.
// Depends on sts_pkg; quotient magnitude must fit DIV_STEPS bits.
module sts_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  sts_pkg::wide_type num,
   input  sts_pkg::wide_type den,
   output logic done,
   output sts_pkg::wide_type q
);
   import sts_pkg::*;

   localparam int CNT_BITS = $clog2(DIV_STEPS);

   logic busy_ff;
   logic done_ff;
   logic neg_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [WW-1:0] rem_ff;
   logic [WW-1:0] den_ff;
   logic [DIV_STEPS-1:0] q_ff;
   logic [WW-1:0] num_mag;
   logic [WW-1:0] trial;
   logic ge;

   assign num_mag = absw(num);
   assign trial = {rem_ff[WW-2:0], q_ff[DIV_STEPS-1]};
   assign ge = trial >= den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= num_mag >> DIV_STEPS;
            q_ff <= num_mag[DIV_STEPS-1:0];
            den_ff <= $unsigned(den);
            neg_ff <= num < 0;
         end else if (busy_ff) begin
            rem_ff <= ge ? trial - den_ff : trial;
            q_ff <= {q_ff[DIV_STEPS-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign q = neg_ff ? -wide_type'(q_ff) : wide_type'(q_ff);

endmodule

FILE: sv/sts_ctrl.sv
// Sequencer: walks the per-channel step list, starts the shared units, pushes words.
// Depends on sts_pkg for step codes and the command/status structs.
module sts_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  sts_pkg::status_type status,
   output sts_pkg::cmd_type cmd
);
   import sts_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_PUSH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [1:0] tsel_ff, tsel_in;
   logic ch_ff, ch_in;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      tsel_in = tsel_ff;
      ch_in = ch_ff;
      req_ready = 1'b0;
      cmd.load = 1'b0;
      cmd.start = 1'b0;
      cmd.finish = 1'b0;
      cmd.push = 1'b0;
      cmd.step = step_ff;
      cmd.tsel = tsel_ff;
      cmd.ch = ch_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ISSUE;
               step_in = STEP_U;
               tsel_in = TSEL_BIASED;
               ch_in = 1'b0;
            end
         end
         ST_ISSUE: begin
            cmd.start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.unit_done) begin
               cmd.finish = 1'b1;
               state_in = ST_ISSUE;
               case (step_ff)
                  STEP_U: step_in = STEP_DRV;
                  STEP_DRV: begin
                     step_in = STEP_TSQ;
                     tsel_in = TSEL_BIASED;
                  end
                  STEP_TSQ: step_in = STEP_TNUM;
                  STEP_TNUM: step_in = STEP_TDIV;
                  STEP_TDIV: begin
                     case (tsel_ff)
                        TSEL_BIASED: begin
                           step_in = STEP_TSQ;
                           tsel_in = TSEL_BIAS;
                        end
                        TSEL_BIAS: step_in = STEP_ODD;
                        default: step_in = STEP_EMUL;
                     endcase
                  end
                  STEP_ODD: begin
                     step_in = STEP_TSQ;
                     tsel_in = TSEL_ODD;
                  end
                  STEP_EMUL: step_in = STEP_OMUL;
                  STEP_OMUL: step_in = STEP_BLEND;
                  STEP_BLEND: step_in = STEP_DC;
                  STEP_DC: step_in = STEP_LP;
                  STEP_LP: step_in = STEP_MIXD;
                  STEP_MIXD: step_in = STEP_MIXW;
                  STEP_MIXW: step_in = STEP_OG;
                  default: begin
                     if (ch_ff) begin
                        state_in = ST_PUSH;
                     end else begin
                        ch_in = 1'b1;
                        step_in = STEP_U;
                     end
                  end
               endcase
            end
         end
         default: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= STEP_U;
         tsel_ff <= TSEL_BIASED;
         ch_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         tsel_ff <= tsel_in;
         ch_ff <= ch_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_load_starts_left: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_ISSUE && step_ff == STEP_U && !ch_ff))
      else $error("accepted word did not start the left channel");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.unit_done |-> state_ff == ST_WAIT)
      else $error("unit finished outside the wait state");
   a_issue_then_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE |=> (state_ff == ST_WAIT && !status.unit_done))
      else $error("unit finished right after start");
`endif

endmodule

FILE: sv/sts_dp.sv
// Datapath: settings, channel state, working registers, shared multiplier and divider.
// Depends on sts_pkg, sts_mul and sts_div; driven by commands from sts_ctrl.
module sts_dp #(
   parameter int SAMPLE_BITS = sts_pkg::SAMPLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  sts_pkg::cmd_type cmd,
   output sts_pkg::status_type status,
   input  logic signed [SAMPLE_BITS-1:0] left_in,
   input  logic signed [SAMPLE_BITS-1:0] right_in,
   input  logic csr_we,
   input  logic [sts_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [sts_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] left_out,
   output logic signed [SAMPLE_BITS-1:0] right_out
);
   import sts_pkg::*;

   localparam int FB = SAMPLE_BITS - 1;
   localparam int IN_UP = (FB <= FRAC) ? FRAC - FB : 0;
   localparam int IN_DN = (FB > FRAC) ? FB - FRAC : 0;
   localparam int OUT_UP = (FB >= FRAC) ? FB - FRAC : 0;
   localparam int OUT_DN = (FB < FRAC) ? FRAC - FB : 0;
   localparam wide_type OUT_LIM = wide_type'(1) <<< FB;

   logic [17:0] ig_ff;
   logic [16:0] drv_ff;
   logic signed [17:0] bias_ff;
   logic [16:0] ew_ff;
   logic [16:0] ow_ff;
   logic [16:0] mix_ff;
   logic [16:0] og_ff;
   logic [15:0] hc_ff;

   logic signed [SAMPLE_BITS-1:0] left_ff, right_ff;
   logic signed [SAMPLE_BITS-1:0] out_l_ff, out_r_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_l_ff, rsp_r_ff;
   logic rsp_valid_ff;
   state_type dc_ff [2];
   state_type lp_ff [2];
   wide_type u_ff, driven_ff, xarg_ff, xc_ff, x2_ff, num_ff, acc_ff, mixed_ff, m_ff;
   wide_type t_ff [3];
   state_type wet_ff;

   logic signed [SAMPLE_BITS-1:0] smp;
   wide_type dry, hb, drv4, drv3, wsum, dry_w, tanh_den, xsrc, xc;
   wide_type mul_a, mul_b, div_num, div_den, mul_p, div_q;
   wide_type blend_v, og_v, out_v;
   state_type wet_blend, dc_new, lp_new;
   logic use_div, mul_done, div_done;

   assign smp = cmd.ch ? right_ff : left_ff;
   assign dry = rnd_shift(wide_type'(smp) <<< IN_UP, IN_DN);
   assign hb = wide_type'(bias_ff) <<< 11;
   assign drv4 = UNITY_Q16 + (wide_type'(drv_ff) <<< 2);
   assign drv3 = UNITY_Q16 + (wide_type'(drv_ff) <<< 1) + wide_type'(drv_ff);
   assign wsum = wide_type'(ew_ff) + wide_type'(ow_ff);
   assign dry_w = UNITY_Q16 - wide_type'(mix_ff);
   assign tanh_den = TANH_K27 + (x2_ff <<< 3) + x2_ff;

   always_comb begin
      case (cmd.tsel)
         TSEL_BIASED: xsrc = driven_ff + hb;
         TSEL_BIAS: xsrc = hb;
         default: xsrc = xarg_ff;
      endcase
   end
   assign xc = clampw(xsrc, -TANH_LIM, TANH_LIM);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_num = '0;
      div_den = '0;
      use_div = 1'b0;
      case (cmd.step)
         STEP_U: begin
            mul_a = dry;
            mul_b = wide_type'(ig_ff);
         end
         STEP_DRV: begin
            mul_a = u_ff;
            mul_b = drv4;
         end
         STEP_TSQ: begin
            mul_a = xc;
            mul_b = xc;
         end
         STEP_TNUM: begin
            mul_a = TANH_K27 + x2_ff;
            mul_b = xc_ff;
         end
         STEP_TDIV: begin
            use_div = 1'b1;
            div_num = num_ff;
            div_den = tanh_den;
         end
         STEP_ODD: begin
            mul_a = driven_ff;
            mul_b = drv3;
         end
         STEP_EMUL: begin
            mul_a = t_ff[0] - t_ff[1];
            mul_b = wide_type'(ew_ff);
         end
         STEP_OMUL: begin
            mul_a = t_ff[2];
            mul_b = wide_type'(ow_ff);
         end
         STEP_BLEND: begin
            use_div = 1'b1;
            div_num = acc_ff;
            div_den = wsum;
         end
         STEP_DC: begin
            mul_a = wide_type'(wet_ff);
            mul_b = DC_COEFF;
         end
         STEP_LP: begin
            mul_a = wide_type'(wet_ff) - wide_type'(lp_ff[cmd.ch]);
            mul_b = wide_type'(hc_ff);
         end
         STEP_MIXD: begin
            mul_a = dry;
            mul_b = dry_w;
         end
         STEP_MIXW: begin
            mul_a = wide_type'(wet_ff);
            mul_b = wide_type'(mix_ff);
         end
         default: begin
            mul_a = m_ff;
            mul_b = wide_type'(og_ff);
         end
      endcase
   end

   sts_mul u_mul (
      .clock(clock),
      .reset(reset),
      .start(cmd.start && !use_div),
      .a(mul_a),
      .b(mul_b),
      .done(mul_done),
      .p(mul_p)
   );

   sts_div u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.start && use_div),
      .num(div_num),
      .den(div_den),
      .done(div_done),
      .q(div_q)
   );

   assign blend_v = (wsum != 0) ? div_q : '0;
   assign wet_blend = sat32(blend_v - wide_type'(dc_ff[cmd.ch]));
   assign dc_new = sat32(mixed_ff - rnd_shift(mul_p, 30));
   assign lp_new = sat32(wide_type'(lp_ff[cmd.ch]) + rnd_shift(mul_p, 16));
   assign og_v = rnd_shift(rnd_shift(mul_p, 16) <<< OUT_UP, OUT_DN);
   assign out_v = clampw(og_v, -OUT_LIM, OUT_LIM - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         ig_ff <= RST_INPUT_GAIN;
         drv_ff <= RST_DRIVE;
         bias_ff <= RST_BIAS;
         ew_ff <= RST_EVEN_WEIGHT;
         ow_ff <= RST_ODD_WEIGHT;
         mix_ff <= RST_WET_MIX;
         og_ff <= RST_OUTPUT_GAIN;
         hc_ff <= RST_HF_COEFF;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INPUT_GAIN: ig_ff <= csr_wdata;
            CSR_DRIVE: drv_ff <= csr_wdata[16:0];
            CSR_BIAS: bias_ff <= $signed(csr_wdata);
            CSR_EVEN_WEIGHT: ew_ff <= csr_wdata[16:0];
            CSR_ODD_WEIGHT: ow_ff <= csr_wdata[16:0];
            CSR_WET_MIX: mix_ff <= csr_wdata[16:0];
            CSR_OUTPUT_GAIN: og_ff <= csr_wdata[16:0];
            CSR_HF_COEFF: hc_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff[0] <= '0;
         dc_ff[1] <= '0;
         lp_ff[0] <= '0;
         lp_ff[1] <= '0;
      end else if (cmd.finish) begin
         case (cmd.step)
            STEP_DC: dc_ff[cmd.ch] <= dc_new;
            STEP_LP: begin
               if (drv_ff > LP_DRIVE_MIN) begin
                  lp_ff[cmd.ch] <= lp_new;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_ff <= left_in;
         right_ff <= right_in;
      end
      if (cmd.start && cmd.step == STEP_TSQ) begin
         xc_ff <= xc;
      end
      if (cmd.finish) begin
         case (cmd.step)
            STEP_U: u_ff <= rnd_shift(mul_p, 16);
            STEP_DRV: driven_ff <= clampw(rnd_shift(mul_p, 16),
                                          -72'sd2147483648, 72'sd2147483647);
            STEP_TSQ: x2_ff <= mul_p >>> FRAC;
            STEP_TNUM: num_ff <= mul_p;
            STEP_TDIV: t_ff[cmd.tsel] <= div_q;
            STEP_ODD: xarg_ff <= rnd_shift(mul_p, 16);
            STEP_EMUL: acc_ff <= mul_p;
            STEP_OMUL: acc_ff <= acc_ff + mul_p;
            STEP_BLEND: begin
               mixed_ff <= blend_v;
               wet_ff <= wet_blend;
            end
            STEP_LP: begin
               if (drv_ff > LP_DRIVE_MIN) begin
                  wet_ff <= lp_new;
               end
            end
            STEP_MIXD: acc_ff <= mul_p;
            STEP_MIXW: m_ff <= rnd_shift(acc_ff + mul_p, 16);
            STEP_OG: begin
               if (cmd.ch) begin
                  out_r_ff <= out_v[SAMPLE_BITS-1:0];
               end else begin
                  out_l_ff <= out_v[SAMPLE_BITS-1:0];
               end
            end
            default: ;
         endcase
      end
      if (cmd.push) begin
         rsp_l_ff <= out_l_ff;
         rsp_r_ff <= out_r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.unit_done = mul_done | div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign left_out = rsp_l_ff;
   assign right_out = rsp_r_ff;

endmodule

FILE: sv/stereo_tube_saturator_core.sv
// Stereo tube saturator top level: input and result channels, settings port.
// Depends on sts_pkg, sts_req_if, sts_rsp_if, sts_ctrl and sts_dp.
//
// Usage: one stereo word enters on req_chan (valid/ready); one processed word
// leaves on rsp_chan. Settings are to be written on csr_we/csr_index/csr_wdata
// only while the block is idle; the block does not enforce this. Writes take
// effect at once and are never read back. Processing: the block works on one
// word at a time. Each channel runs 16 multiplies and 4 divides on one shared
// shift-add multiplier and one restoring divider; the multiplier works in 32
// one-bit steps. A new word can be accepted in the cycle after the previous
// result is handed to the output register.
// Reset: synchronous, active high; settings return to their defaults and the
// DC-blocker and lowpass states clear to zero.
// Stall: a finished word waits in the output register; the next word is
// accepted and processed meanwhile, and only its final hand-off holds until
// the receiver takes the waiting word.
module stereo_tube_saturator_core #(
   parameter int SAMPLE_BITS = sts_pkg::SAMPLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   sts_req_if.sink req_chan,
   sts_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [sts_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [sts_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import sts_pkg::*;

   cmd_type cmd;
   status_type status;

   sts_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .status(status),
      .cmd(cmd)
   );

   sts_dp #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .left_in(req_chan.left_in),
      .right_in(req_chan.right_in),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .left_out(rsp_chan.left_out),
      .right_out(rsp_chan.right_out)
   );

endmodule

FILE: tb/tb_stereo_tube_saturator_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for stereo_tube_saturator_core: directed table, then random words
// over several settings, each result compared with an in-bench fixed-point saturator model
// or a typed expected pair. Depends on sts_pkg, sts_req_if, sts_rsp_if and the core.
module tb_stereo_tube_saturator_core;
   import sts_pkg::*;

   localparam int SB = SAMPLE_BITS_DEF;
   localparam longint ONE_Q = 64'sd1 <<< 28;
   localparam longint LIMIT_CYCLES = 6000000;
   localparam int SETTLE_CYCLES = 1600;

   typedef logic signed [SB-1:0] smp_type;
   typedef struct packed {
      smp_type left;
      smp_type right;
   } pair_type;
   typedef struct {
      smp_type left;
      smp_type right;
      bit typed;
      smp_type exp_left;
      smp_type exp_right;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   sts_req_if req_chan();
   sts_rsp_if rsp_chan();

   stereo_tube_saturator_core dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   logic [17:0] reg_val [8];
   longint dc_mem [2];
   longint lp_mem [2];
   pair_type expected_pairs [$];
   int errors = 0;
   longint cycle_cnt = 0;
   int results_seen = 0;
   bit rx_no_idle = 0;

   initial begin
      req_chan.valid = 0;
      req_chan.left_in = '0;
      req_chan.right_in = '0;
      rsp_chan.ready = 0;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic longint rshift(longint v, int k);
      return (v + (64'sd1 <<< (k - 1))) >>> k;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint sat_state(longint v);
      return clip(v, -64'sd2147483648, 64'sd2147483647);
   endfunction

   function automatic longint soft_clip(longint x);
      longint x2, num, den;
      if (x < -3 * ONE_Q) return -ONE_Q;
      if (x > 3 * ONE_Q) return ONE_Q;
      x2 = (x * x) >>> 28;
      num = x * (27 * ONE_Q + x2);
      den = 27 * ONE_Q + 9 * x2;
      return num / den;
   endfunction

   function automatic smp_type saturate_channel(smp_type raw, int ch);
      longint ig, drv, bias, ew, ow, mix, og, hc;
      longint dry, u, driven, hb, even, odd, wsum, mixed, wet, s, m;
      ig = reg_val[CSR_INPUT_GAIN];
      drv = reg_val[CSR_DRIVE][16:0];
      bias = longint'($signed(reg_val[CSR_BIAS]));
      ew = reg_val[CSR_EVEN_WEIGHT][16:0];
      ow = reg_val[CSR_ODD_WEIGHT][16:0];
      mix = reg_val[CSR_WET_MIX][16:0];
      og = reg_val[CSR_OUTPUT_GAIN][16:0];
      hc = reg_val[CSR_HF_COEFF][15:0];
      dry = longint'(raw) * 32;
      u = rshift(dry * ig, 16);
      driven = rshift(u * (65536 + 4 * drv), 16);
      driven = sat_state(driven);
      hb = bias * 2048;
      even = soft_clip(driven + hb) - soft_clip(hb);
      odd = soft_clip(rshift(driven * (65536 + 3 * drv), 16));
      wsum = ew + ow;
      mixed = (wsum > 0) ? (even * ew + odd * ow) / wsum : 0;
      wet = sat_state(mixed - dc_mem[ch]);
      dc_mem[ch] = sat_state(mixed - rshift(wet * 64'sd1068373115, 30));
      if (drv > 6553) begin
         s = lp_mem[ch];
         s = sat_state(s + rshift(hc * (wet - s), 16));
         lp_mem[ch] = s;
         wet = s;
      end
      m = rshift(dry * (65536 - mix) + wet * mix, 16);
      m = rshift(m * og, 16);
      m = clip(rshift(m, 5), -(64'sd1 <<< 23), (64'sd1 <<< 23) - 1);
      return smp_type'(m);
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // receiver: random ready, one long hold-off after 120 results
   initial begin
      int g;
      bit held;
      held = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && results_seen == 120) begin
            held = 1;
            rsp_chan.ready = 0;
            repeat (6000) @(negedge clock);
         end
         g = rx_no_idle ? 0 : gap_len();
         if (g > 0) begin
            rsp_chan.ready = 0;
            repeat (g) @(negedge clock);
         end
         rsp_chan.ready = 1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      pair_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen <= results_seen + 1;
         if (expected_pairs.size() == 0) begin
            $error("unexpected word: left_out %0d right_out %0d",
                   rsp_chan.left_out, rsp_chan.right_out);
            errors++;
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_chan.left_out !== want.left) begin
               $error("left_out expected %0d actual %0d", want.left, rsp_chan.left_out);
               errors++;
            end
            if (rsp_chan.right_out !== want.right) begin
               $error("right_out expected %0d actual %0d", want.right, rsp_chan.right_out);
               errors++;
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [17:0] val);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_INPUT_GAIN, CSR_BIAS: reg_val[idx] = val;
         CSR_HF_COEFF: reg_val[idx] = {2'b0, val[15:0]};
         default: reg_val[idx] = {1'b0, val[16:0]};
      endcase
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic load_settings(logic [17:0] s [8]);
      for (int i = 0; i < 8; i++) write_reg(i[CSR_IDX_BITS-1:0], s[i]);
   endtask

   task automatic wait_drained();
      while (expected_pairs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_word(smp_type l, smp_type r, bit typed, smp_type el, smp_type er,
                            bit no_gap);
      pair_type p;
      int g;
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_chan.valid = 0;
         repeat (g) @(negedge clock);
      end
      req_chan.valid = 1;
      req_chan.left_in = l;
      req_chan.right_in = r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      p.left = saturate_channel(l, 0);
      p.right = saturate_channel(r, 1);
      if (typed) begin
         p.left = el;
         p.right = er;
      end
      expected_pairs.push_back(p);
      @(negedge clock);
   endtask

   function automatic smp_type rand_sample();
      int k;
      k = $urandom_range(0, 9);
      if (k < 5) return smp_type'($urandom);
      if (k < 8) return smp_type'($signed($urandom_range(0, 8191)) - 4096);
      return ($urandom_range(0, 1)) ? smp_type'(24'h7fffff) : smp_type'(24'h800000);
   endfunction

   initial begin
      row_type dir_rows [$];
      logic [17:0] set_a [8];
      logic [17:0] fixed_sets [4][8];
      int n_words;
      bit fast;

      fixed_sets[0] = '{18'h3ffff, 18'd65536, 18'd65536, 18'd65536, 18'd65536,
                        18'h1ffff, 18'h1ffff, 18'hffff};
      fixed_sets[1] = '{18'd65536, 18'd0, 18'h30000, 18'd0, 18'd0, 18'd65536,
                        18'd65536, 18'd0};
      fixed_sets[2] = '{18'd0, 18'd6553, 18'h20000, 18'd1, 18'd0, 18'd0, 18'd0, 18'd1};
      fixed_sets[3] = '{18'd131072, 18'd6554, 18'h1ffff, 18'd0, 18'h1ffff, 18'd65536,
                        18'd32768, 18'd40000};

      reg_val = '{RST_INPUT_GAIN, RST_DRIVE, RST_BIAS, RST_EVEN_WEIGHT, RST_ODD_WEIGHT,
                  RST_WET_MIX, RST_OUTPUT_GAIN, RST_HF_COEFF};
      dc_mem = '{0, 0};
      lp_mem = '{0, 0};

      dir_rows.push_back('{24'sd0, 24'sd0, 1, 24'sd0, 24'sd0});
      dir_rows.push_back('{24'h7fffff, 24'h800000, 0, 0, 0});
      dir_rows.push_back('{24'h800000, 24'h7fffff, 0, 0, 0});
      dir_rows.push_back('{24'h7fffff, 24'h7fffff, 0, 0, 0});
      dir_rows.push_back('{24'h800000, 24'h800000, 0, 0, 0});
      dir_rows.push_back('{24'sd1, -24'sd1, 0, 0, 0});
      dir_rows.push_back('{24'h400000, 24'hc00000, 0, 0, 0});
      dir_rows.push_back('{24'h100000, -24'sd100000, 0, 0, 0});
      dir_rows.push_back('{24'h555555, 24'haaaaaa, 0, 0, 0});
      dir_rows.push_back('{24'sd0, 24'sd0, 0, 0, 0});
      dir_rows.push_back('{24'sd0, 24'sd0, 0, 0, 0});
      dir_rows.push_back('{24'h020000, 24'hfe0000, 0, 0, 0});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (dir_rows[i])
         send_word(dir_rows[i].left, dir_rows[i].right, dir_rows[i].typed,
                   dir_rows[i].exp_left, dir_rows[i].exp_right, 0);

      for (int ph = 0; ph < 10; ph++) begin
         req_chan.valid = 0;
         wait_drained();
         if (ph < 4) begin
            load_settings(fixed_sets[ph]);
            n_words = 50;
         end else begin
            set_a[0] = 18'($urandom_range(0, 131072));
            set_a[1] = 18'($urandom_range(0, 65536));
            set_a[2] = 18'($signed($urandom_range(0, 131072)) - 65536);
            set_a[3] = 18'($urandom_range(0, 65536));
            set_a[4] = 18'($urandom_range(0, 65536));
            set_a[5] = 18'($urandom_range(0, 65536));
            set_a[6] = 18'($urandom_range(0, 65536));
            set_a[7] = 18'($urandom_range(0, 65535));
            load_settings(set_a);
            n_words = 110;
         end
         fast = (ph == 5 || ph == 8);
         rx_no_idle = fast;
         for (int k = 0; k < n_words; k++) begin
            if (ph == 6 && k == 40) begin
               req_chan.valid = 0;
               while (expected_pairs.size() != 0) @(negedge clock);
            end
            send_word(rand_sample(), rand_sample(), 0, 0, 0, fast);
         end
      end
      req_chan.valid = 0;
      rx_no_idle = 0;

      wait_drained();
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/sts_pkg.sv
sv/sts_req_if.sv
sv/sts_rsp_if.sv
sv/sts_mul.sv
sv/sts_div.sv
sv/sts_ctrl.sv
sv/sts_dp.sv
sv/stereo_tube_saturator_core.sv
tb/tb_stereo_tube_saturator_core.sv
